// File: rtl/hsv_pkg.sv
// HSV to RGB converter package: field widths, hue sector codes and the
// divide-by-(255*65536) helper. No dependencies.
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int HUE_W  = 16;                  // hue, fraction of a turn
  localparam int CHAN_W = 8;                   // S, V, alpha and RGB
  localparam int FRAC_W = 16;                  // fraction within a sector
  localparam int SECT_W = 3;                   // sector number 0..5
  localparam int H6_W   = HUE_W + SECT_W;      // hue * 6
  localparam int PROD_W = CHAN_W + FRAC_W;     // S * fraction, below 255 * 2^16
  localparam int NUM_W  = CHAN_W + PROD_W;     // V * (den - S * fraction)

  // 255 * 65536, the common denominator of p, q and t
  localparam logic [PROD_W-1:0] DEN = PROD_W'(255 * 65536);
  localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(255);

  // Hue sectors, one per sixth of a turn
  typedef enum logic [SECT_W-1:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

  // floor(num / (255 * 65536)); the top 16 bits are divided by 255 through
  // an estimate that is low by at most one, then one compare and correct.
  function automatic logic [CHAN_W-1:0] div_den(input logic [NUM_W-1:0] num);
    logic [15:0] x;
    logic [15:0] est;
    logic [7:0]  q0;
    logic [15:0] rem;
    x   = num[NUM_W-1:NUM_W-16];
    est = x + {8'h00, x[15:8]};
    q0  = est[15:8];
    rem = x - ({q0, 8'h00} - {8'h00, q0});
    if (rem >= {8'h00, CHAN_MAX}) begin
      div_den = q0 + 8'd1;
    end else begin
      div_den = q0;
    end
  endfunction

endpackage

// File: rtl/hsv_if.sv
// Valid/ready channel interfaces for the HSV to RGB converter: HSV request
// in, RGB result out. Depends on hsv_pkg.
`timescale 1ns / 1ps

interface hsv_in_if import hsv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] brightness;
  logic [CHAN_W-1:0] opacity;

  modport source (output valid, hue, saturation, brightness, opacity, input ready);
  modport sink   (input valid, hue, saturation, brightness, opacity, output ready);
endinterface

interface hsv_out_if import hsv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

// File: rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter top level: four-stage pipeline with per-stage valid
// bits. Depends on hsv_pkg and the channel interfaces in hsv_if.sv.
`timescale 1ns / 1ps

// Converts one HSV colour (16-bit hue as a fraction of a turn, 8-bit
// saturation and value as fractions of 255) plus alpha into 8-bit RGB and
// alpha, truncating. It takes one request per clock while the pipeline has
// room and presents each result through four register stages: hue split,
// S times fraction, V times the remainder, then the divide by 255*65536 and
// channel selection. Each stage
// holds its item only while the stage after it is full and stalled, so the
// input keeps taking requests as long as there is a free slot anywhere in the
// pipeline. Alpha travels alongside unchanged. There is no state beyond the
// pipeline and no configuration.
module hsv_to_rgb_converter_top
  import hsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hsv_in_if.sink    in_ch,
  hsv_out_if.source out_ch
);

  // ---------------- stage valid bits and readies ----------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  assign v1_nxt = rdy1 ? in_ch.valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // ---------------- stage 1: hue * 6, split into sector and fraction ----------------
  logic [H6_W-1:0]   h6;
  logic [SECT_W-1:0] sec1_r;
  logic [FRAC_W-1:0] frac1_r;
  logic [CHAN_W-1:0] s1_r, val1_r, a1_r;

  assign h6 = {1'b0, in_ch.hue, 2'b00} + {2'b00, in_ch.hue, 1'b0};

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      sec1_r  <= h6[H6_W-1:FRAC_W];
      frac1_r <= h6[FRAC_W-1:0];
      s1_r    <= in_ch.saturation;
      val1_r  <= in_ch.brightness;
      a1_r    <= in_ch.opacity;
    end
  end

  // ---------------- stage 2: S * F and S * (1 - F) ----------------
  logic [PROD_W-1:0] sf_q, sf_t;
  logic [PROD_W-1:0] sfq2_r, sft2_r;
  logic [SECT_W-1:0] sec2_r;
  logic [CHAN_W-1:0] s2_r, val2_r, a2_r;

  assign sf_q = {{FRAC_W{1'b0}}, s1_r} * {{CHAN_W{1'b0}}, frac1_r};
  assign sf_t = {s1_r, {FRAC_W{1'b0}}} - sf_q;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      sfq2_r <= sf_q;
      sft2_r <= sf_t;
      sec2_r <= sec1_r;
      s2_r   <= s1_r;
      val2_r <= val1_r;
      a2_r   <= a1_r;
    end
  end

  // ---------------- stage 3: V times (den - S), (den - S * F) and (den - S * (1 - F)) ----------------
  logic [PROD_W-1:0] m_p, m_q, m_t;
  logic [NUM_W-1:0]  val2_w;
  logic [NUM_W-1:0]  nump3_r, numq3_r, numt3_r;
  logic [SECT_W-1:0] sec3_r;
  logic [CHAN_W-1:0] val3_r, a3_r;

  assign m_p = {CHAN_MAX - s2_r, {FRAC_W{1'b0}}};
  assign m_q = DEN - sfq2_r;
  assign m_t = DEN - sft2_r;
  assign val2_w = {{PROD_W{1'b0}}, val2_r};

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      nump3_r <= val2_w * {{CHAN_W{1'b0}}, m_p};
      numq3_r <= val2_w * {{CHAN_W{1'b0}}, m_q};
      numt3_r <= val2_w * {{CHAN_W{1'b0}}, m_t};
      sec3_r  <= sec2_r;
      val3_r  <= val2_r;
      a3_r    <= a2_r;
    end
  end

  // ---------------- stage 4: divide and pick channel order ----------------
  logic [CHAN_W-1:0] p_c, q_c, t_c;
  logic [CHAN_W-1:0] r_c, g_c, b_c;
  logic [CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;

  assign p_c = div_den(nump3_r);
  assign q_c = div_den(numq3_r);
  assign t_c = div_den(numt3_r);

  always_comb begin
    case (sector_t'(sec3_r))
      SEC_R_Y: begin r_c = val3_r; g_c = t_c;    b_c = p_c;    end
      SEC_Y_G: begin r_c = q_c;    g_c = val3_r; b_c = p_c;    end
      SEC_G_C: begin r_c = p_c;    g_c = val3_r; b_c = t_c;    end
      SEC_C_B: begin r_c = p_c;    g_c = q_c;    b_c = val3_r; end
      SEC_B_M: begin r_c = t_c;    g_c = p_c;    b_c = val3_r; end
      default: begin r_c = val3_r; g_c = p_c;    b_c = q_c;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      red_r   <= r_c;
      green_r <= g_c;
      blue_r  <= b_c;
      alpha_r <= a3_r;
    end
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.red       = red_r;
  assign out_ch.green     = green_r;
  assign out_ch.blue      = blue_r;
  assign out_ch.alpha_out = alpha_r;

  // ---------------- assertions ----------------
  // hue * 6 never reaches sector six or seven
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (sec1_r <= SECT_W'(5)))
    else $error("hue split gave a sector above five");

  // q and t never fall below p, as the fraction is below one
  a_pqt_order: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (numq3_r >= nump3_r) && (numt3_r >= nump3_r))
    else $error("q or t product below p product");

  // a stalled middle stage keeps its item
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r && $stable(sec2_r) && $stable(a2_r))
    else $error("stage 2 lost or changed a stalled request");

  // a stalled divide stage keeps its products
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> v3_r && $stable(numq3_r) && $stable(numt3_r))
    else $error("stage 3 lost or changed a stalled request");

  // with zero saturation all three products reduce to V
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rdy3 && (s2_r == '0)) |=> (p_c == val3_r) && (q_c == val3_r))
    else $error("zero saturation did not give a grey result");

endmodule
